// ===== hw/rtl/pip_pkg.sv =====
package pip_pkg;

  localparam int COORD_BITS_DEF = 16;

  // control bits that travel with a vertex down the pipe
  typedef struct packed {
    logic first_vertex;
    logic last_vertex;
    logic last_point;
    logic active;
  } flags_t;

endpackage

// ===== hw/rtl/point_in_polygon_crossing_core.sv =====
// channel | handshake           | payload
// --------+---------------------+-----------------------------------------------
// in      | in_valid / in_stall | point_x/y, vertex_x/y, first/last_vertex,
//         |                     | last_point, active
// out     | out_valid/out_stall | inside_res, any_inside, group_done
//
// One vertex item per cycle while no held result stalls the input. A result is
// offered once the last vertex of a pass has gone through a difference stage, a
// product stage (four multipliers of COORD_BITS+1 bits), then the compare and
// parity update feeding the output register. Synchronous active-low reset clears
// the valid bits, vertex history and pass state. in_stall rises only while a
// finished result is held by out_stall and the pipe behind it is full.
module point_in_polygon_crossing_core #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_vertex_x,
  input  logic signed [COORD_BITS-1:0] in_vertex_y,
  input  logic                         in_first_vertex,
  input  logic                         in_last_vertex,
  input  logic                         in_last_point,
  input  logic                         in_active,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_inside_res,
  output logic                         out_any_inside,
  output logic                         out_group_done
);

  localparam int W  = COORD_BITS;
  localparam int PW = 2 * COORD_BITS + 2;

  // vertex history
  logic signed [W-1:0] start_x_r, start_y_r, prior_x_r, prior_y_r;

  // difference stage
  logic                s1_v_r;
  pip_pkg::flags_t     s1_flags_r;
  logic signed [W:0]   s1_dx_r [2];
  logic signed [W:0]   s1_dy_r [2];
  logic signed [W:0]   s1_ax_r [2];
  logic signed [W:0]   s1_by_r [2];
  logic                s1_str_r [2];

  // product stage
  logic                s2_v_r;
  pip_pkg::flags_t     s2_flags_r;
  logic signed [PW-1:0] s2_pa_r [2];
  logic signed [PW-1:0] s2_pb_r [2];
  logic                s2_str_r [2];

  // pass state
  logic parity_r, pass_active_r, group_hit_r;
  logic parity_nxt, pass_active_nxt, group_hit_nxt, inside_nxt;

  logic out_valid_r, out_inside_r, out_any_r, out_done_r;

  logic in_take, s1_ready, s2_ready, s2_take, out_ready;

  pip_pkg::flags_t     in_flags;
  logic signed [W:0]   dx_nxt [2];
  logic signed [W:0]   dy_nxt [2];
  logic signed [W:0]   ax_nxt [2];
  logic signed [W:0]   by_nxt [2];
  logic                str_nxt [2];
  logic signed [W-1:0] ex1 [2];
  logic signed [W-1:0] ey1 [2];
  logic signed [W-1:0] ex2 [2];
  logic signed [W-1:0] ey2 [2];
  logic                edge_hit [2];

  // handshake chain
  assign out_ready = !out_valid_r || !out_stall;
  assign s2_take   = s2_v_r && (!s2_flags_r.last_vertex || out_ready);
  assign s2_ready  = !s2_v_r || s2_take;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_take   = in_valid && s1_ready;

  assign in_flags = '{first_vertex: in_first_vertex, last_vertex: in_last_vertex,
                      last_point: in_last_point, active: in_active};

  // edge 0: previous vertex to this one; edge 1: this one back to the start
  always_comb begin
    ex1[0] = prior_x_r;
    ey1[0] = prior_y_r;
    ex2[0] = in_vertex_x;
    ey2[0] = in_vertex_y;
    ex1[1] = in_vertex_x;
    ey1[1] = in_vertex_y;
    ex2[1] = in_first_vertex ? in_vertex_x : start_x_r;
    ey2[1] = in_first_vertex ? in_vertex_y : start_y_r;
    for (int e = 0; e < 2; e++) begin
      // a horizontal edge never straddles, so no separate check
      str_nxt[e] = (in_point_y < ey1[e]) != (in_point_y < ey2[e]);
      dx_nxt[e]  = {ex2[e][W-1], ex2[e]} - {ex1[e][W-1], ex1[e]};
      dy_nxt[e]  = {ey2[e][W-1], ey2[e]} - {ey1[e][W-1], ey1[e]};
      ax_nxt[e]  = {in_point_x[W-1], in_point_x} - {ex1[e][W-1], ex1[e]};
      by_nxt[e]  = {in_point_y[W-1], in_point_y} - {ey1[e][W-1], ey1[e]};
      if (dy_nxt[e][W]) begin
        dy_nxt[e] = -dy_nxt[e];
        by_nxt[e] = -by_nxt[e];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      prior_x_r <= '0;
      prior_y_r <= '0;
    end else if (in_take) begin
      prior_x_r <= in_vertex_x;
      prior_y_r <= in_vertex_y;
      if (in_first_vertex) begin
        start_x_r <= in_vertex_x;
        start_y_r <= in_vertex_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_flags_r <= in_flags;
      for (int e = 0; e < 2; e++) begin
        s1_dx_r[e]  <= dx_nxt[e];
        s1_dy_r[e]  <= dy_nxt[e];
        s1_ax_r[e]  <= ax_nxt[e];
        s1_by_r[e]  <= by_nxt[e];
        s1_str_r[e] <= str_nxt[e];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
  end

  // left of the crossing <=> ax*|dy| < by'*dx, exact in PW bits
  always_ff @(posedge clk) begin
    if (s1_v_r && s2_ready) begin
      s2_flags_r <= s1_flags_r;
      for (int e = 0; e < 2; e++) begin
        s2_pa_r[e]  <= PW'(s1_ax_r[e]) * PW'(s1_dy_r[e]);
        s2_pb_r[e]  <= PW'(s1_by_r[e]) * PW'(s1_dx_r[e]);
        s2_str_r[e] <= s1_str_r[e];
      end
    end
  end

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      edge_hit[e] = s2_str_r[e] && (s2_pa_r[e] < s2_pb_r[e]);
    end
    parity_nxt      = parity_r;
    pass_active_nxt = pass_active_r;
    if (s2_flags_r.first_vertex) begin
      parity_nxt      = 1'b0;
      pass_active_nxt = s2_flags_r.active;
    end else begin
      parity_nxt = parity_r ^ edge_hit[0];
    end
    if (s2_flags_r.last_vertex) begin
      parity_nxt = parity_nxt ^ edge_hit[1];
    end
    inside_nxt    = parity_nxt && pass_active_nxt;
    group_hit_nxt = group_hit_r || inside_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r      <= 1'b0;
      pass_active_r <= 1'b0;
      group_hit_r   <= 1'b0;
    end else if (s2_take) begin
      parity_r      <= parity_nxt;
      pass_active_r <= pass_active_nxt;
      if (s2_flags_r.last_vertex) begin
        group_hit_r <= group_hit_nxt && !s2_flags_r.last_point;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s2_v_r && s2_flags_r.last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_v_r && s2_flags_r.last_vertex) begin
      out_inside_r <= inside_nxt;
      out_any_r    <= group_hit_nxt;
      out_done_r   <= s2_flags_r.last_point;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_any_inside = out_any_r;
  assign out_group_done = out_done_r;

endmodule

// ===== hw/rtl/pip_checker.sv =====
module pip_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_inside_res,
  input logic out_any_inside,
  input logic out_group_done
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inside_res) &&
      $stable(out_any_inside) && $stable(out_group_done))
    else $error("result changed while stalled");

  // the group flag already includes this point
  a_any_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_res |-> out_any_inside)
    else $error("inside without any_inside");

  // back-pressure only comes from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipe not empty after reset");

  // a stalled input item stays offered
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("input item withdrawn while stalled");

endmodule

bind point_in_polygon_crossing_core pip_checker u_pip_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_inside_res (out_inside_res),
  .out_any_inside (out_any_inside),
  .out_group_done (out_group_done)
);
